// ===== hdl/msb_pkg.sv =====
// ----------------------------------------------------------------------------
// msb_pkg
// Shared constants, codes and types for the multi-stack bank.
// ----------------------------------------------------------------------------
package msb_pkg;

    localparam int NUM_STACKS  = 5;
    localparam int STACK_DEPTH = 32;
    localparam int DATA_WIDTH  = 32;

    // Field widths fixed by the port list.
    localparam int SEL_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int LEVEL_W  = 6;
    localparam int STATUS_W = 2;

    localparam int ENTRIES = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NO_STACK = 2'd3
    } status_t;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   level;
        logic               pop_ok;
    } step_result_t;

endpackage

// ===== hdl/msb_elem_ram.sv =====
// ----------------------------------------------------------------------------
// msb_elem_ram
// Single-port element store shared by all stacks, registered read data.
// ----------------------------------------------------------------------------
module msb_elem_ram (
    input  logic                                clk,
    input  msb_pkg::mem_req_t                   req,
    output logic [msb_pkg::DATA_WIDTH-1:0]      rdata
);

    logic [msb_pkg::DATA_WIDTH-1:0] mem [msb_pkg::ENTRIES];
    logic [msb_pkg::DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/msb_fill_ctrl.sv =====
// ----------------------------------------------------------------------------
// msb_fill_ctrl
// Per-stack fill counters, outcome decision and element address generation.
// ----------------------------------------------------------------------------
module msb_fill_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               action,
    input  logic [msb_pkg::SEL_W-1:0]          stack_select,
    input  logic [msb_pkg::VALUE_W-1:0]        push_value,
    output msb_pkg::mem_req_t                  req,
    output msb_pkg::step_result_t              res
);

    logic [msb_pkg::CNT_W-1:0] fill_reg [msb_pkg::NUM_STACKS];
    logic [msb_pkg::CNT_W-1:0] fill_next;
    logic [msb_pkg::CNT_W-1:0] cur_count;
    logic [msb_pkg::IDX_W-1:0] idx;
    logic [msb_pkg::ADDR_W-1:0] base_addr;
    logic                       in_range;

    assign in_range  = (32'(stack_select) < msb_pkg::NUM_STACKS);
    assign idx       = msb_pkg::IDX_W'(stack_select);
    assign cur_count = in_range ? fill_reg[idx] : '0;
    assign base_addr = msb_pkg::ADDR_W'(msb_pkg::ADDR_W'(idx)
                     * msb_pkg::ADDR_W'(msb_pkg::STACK_DEPTH));

    always_comb
    begin
        req.wr_en  = 1'b0;
        req.rd_en  = 1'b0;
        req.addr   = base_addr + msb_pkg::ADDR_W'(cur_count);
        req.wdata  = msb_pkg::DATA_WIDTH'(push_value);
        res.status = msb_pkg::STATUS_DONE;
        res.pop_ok = 1'b0;
        fill_next  = cur_count;

        priority if (!in_range)
        begin
            res.status = msb_pkg::STATUS_NO_STACK;
        end
        else if (action == msb_pkg::ACTION_PUSH)
        begin
            if (32'(cur_count) >= msb_pkg::STACK_DEPTH)
            begin
                res.status = msb_pkg::STATUS_OVERFLOW;
            end
            else
            begin
                req.wr_en = accept;
                fill_next = cur_count + msb_pkg::CNT_W'(1);
            end
        end
        else
        begin
            if (cur_count == '0)
            begin
                res.status = msb_pkg::STATUS_EMPTY;
            end
            else
            begin
                // The top entry sits one below the current count.
                fill_next  = cur_count - msb_pkg::CNT_W'(1);
                req.addr   = base_addr + msb_pkg::ADDR_W'(fill_next);
                req.rd_en  = accept;
                res.pop_ok = 1'b1;
            end
        end

        res.level = fill_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msb_pkg::NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            fill_reg[idx] <= fill_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("element store written and read by one transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> (res.status == msb_pkg::STATUS_DONE && action == msb_pkg::ACTION_PUSH))
        else $error("element store written without a successful push");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_range && action == msb_pkg::ACTION_PUSH
         && res.status == msb_pkg::STATUS_DONE)
        |=> fill_reg[$past(idx)] == msb_pkg::CNT_W'($past(cur_count) + 1'b1))
        else $error("fill count not advanced by a successful push");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_count) <= msb_pkg::STACK_DEPTH)
        else $error("fill count beyond stack depth");

endmodule

// ===== hdl/multi_stack_bank_unit.sv =====
// ----------------------------------------------------------------------------
// multi_stack_bank_unit
// A result is registered and becomes valid in the cycle after its input transfer.
// Throughput: one item per cycle while the result side keeps taking transfers;
// each successful push or pop makes one access to the single element memory port.
// Reset clears every fill count and the result valid flag; the element
// memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module multi_stack_bank_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [msb_pkg::SEL_W-1:0]           stack_select,
    input  logic signed [msb_pkg::VALUE_W-1:0]  push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [msb_pkg::STATUS_W-1:0]        status,
    output logic signed [msb_pkg::VALUE_W-1:0]  popped_value,
    output logic [msb_pkg::LEVEL_W-1:0]         fill_level
);

    msb_pkg::mem_req_t             req;
    msb_pkg::step_result_t         res;
    logic [msb_pkg::DATA_WIDTH-1:0] rdata;
    logic                          accept;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    msb_pkg::status_t              status_reg;
    logic [msb_pkg::CNT_W-1:0]     level_reg;
    logic                          pop_ok_reg;

    // A new item may enter whenever the result register is free or is
    // being emptied by a transfer in the same cycle.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    msb_fill_ctrl u_fill_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .stack_select (stack_select),
        .push_value   (push_value),
        .req          (req),
        .res          (res)
    );

    msb_elem_ram u_elem_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= res.status;
            level_reg  <= res.level;
            pop_ok_reg <= res.pop_ok;
        end
    end

    // The memory read data only changes on a pop transfer, so it holds
    // together with the rest of the result while the output is stalled.
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = pop_ok_reg ? msb_pkg::VALUE_W'(rdata) : '0;
    assign fill_level   = msb_pkg::LEVEL_W'(level_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != msb_pkg::STATUS_DONE) |-> !pop_ok_reg)
        else $error("popped value enabled on a failed action");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while the result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

endmodule
